### rtl/tgfg_pkg.sv
`timescale 1ns / 1ps
package tgfg_pkg;

    localparam int PULSES_PER_REV = 2;
    localparam int DEBOUNCE_US    = 1000;
    localparam int RPM_PERIOD_MS  = 1000;
    localparam int FAN_DELAY_MS   = 30000;
    localparam int MAX_RPM        = 10000;

    localparam int SENSE_PERIOD_MS    = 2000;
    localparam int REGULATE_PERIOD_MS = 1000;
    localparam int MS_PER_MIN         = 60000;

    localparam int TIME_W  = 32;
    localparam int TALLY_W = 16;
    localparam int RPM_W   = 14;
    localparam int TEMP_W  = 12;
    localparam int TGT_W   = 11;
    localparam int HYST_W  = 8;
    localparam int MARG_W  = 9;
    localparam int MODE_W  = 3;
    localparam int OP_W    = 2;
    localparam int CMP_W   = 14;
    localparam int PPR_W   = $clog2(PULSES_PER_REV + 1);
    localparam int DEN_W   = TIME_W + PPR_W;
    localparam int NUM_W   = 32;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEFT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEATER_ALLOWED  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_ALLOWED     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HYSTERESIS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT_MARGIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED       = 3'd7;

    localparam logic [OP_W-1:0] OP_TACH_EDGE   = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK        = 2'd1;
    localparam logic [OP_W-1:0] OP_FAULT_RESET = 2'd2;

    localparam logic [MODE_W-1:0] MODE_IDLE        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HEATING     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COOLING     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVERHEAT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SPEED_FAULT = 3'd4;

    typedef struct packed {
        logic              control_enable;
        logic [TGT_W-1:0]  target_left;
        logic [TGT_W-1:0]  target_right;
        logic              heater_allowed;
        logic              fan_allowed;
        logic [HYST_W-1:0] hysteresis;
        logic [MARG_W-1:0] overheat_margin;
        logic [RPM_W-1:0]  min_speed;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              overheat;
        logic              speed_fault;
        logic [RPM_W-1:0]  fan_speed;
        logic              fan_on;
        logic              heater_on;
    } t_result;

endpackage

### rtl/tgfg_div.sv
`timescale 1ns / 1ps
module tgfg_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tgfg_pkg::NUM_W-1:0]     i_num,
    input  logic [tgfg_pkg::DEN_W-1:0]     i_den,
    output logic                           o_done,
    output logic [tgfg_pkg::NUM_W-1:0]     o_quot
);

    logic [tgfg_pkg::NUM_W-1:0]     r_nq;
    logic [tgfg_pkg::DEN_W-1:0]     r_rem;
    logic [tgfg_pkg::DEN_W-1:0]     r_den;
    logic [tgfg_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [tgfg_pkg::DEN_W:0] w_shift;
    logic [tgfg_pkg::DEN_W:0] w_diff;
    logic                     w_ge;

    // One quotient bit per cycle; the dividend shifts out as the quotient shifts in.
    assign w_shift = {r_rem, r_nq[tgfg_pkg::NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[tgfg_pkg::NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[tgfg_pkg::DEN_W-1:0] : w_shift[tgfg_pkg::DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule

### rtl/tgfg_ctrl.sv
`timescale 1ns / 1ps
module tgfg_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tgfg_pkg::t_cfg                    i_cfg,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  logic [tgfg_pkg::OP_W-1:0]         i_op,
    input  logic [tgfg_pkg::TIME_W-1:0]       i_time_us,
    input  logic [tgfg_pkg::TIME_W-1:0]       i_time_ms,
    input  logic signed [tgfg_pkg::TEMP_W-1:0] i_left_temp,
    input  logic signed [tgfg_pkg::TEMP_W-1:0] i_right_temp,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output tgfg_pkg::t_result                 o_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EDGE  = 4'd1;
    localparam logic [3:0] S_RPM   = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_FAN   = 4'd4;
    localparam logic [3:0] S_GATE  = 4'd5;
    localparam logic [3:0] S_SENSE = 4'd6;
    localparam logic [3:0] S_REG   = 4'd7;
    localparam logic [3:0] S_DELAY = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam int TW = tgfg_pkg::TIME_W;
    localparam int CW = tgfg_pkg::CMP_W;

    logic [3:0] r_state, n_state;

    logic [TW-1:0]                    r_tus, r_tms;
    logic signed [tgfg_pkg::TEMP_W-1:0] r_tl, r_tr;

    logic [tgfg_pkg::TALLY_W-1:0] r_tally, n_tally;
    logic [TW-1:0] r_last_edge, n_last_edge;
    logic [TW-1:0] r_last_rpm, n_last_rpm;
    logic [tgfg_pkg::RPM_W-1:0] r_rpm, n_rpm;
    logic [TW-1:0] r_last_sense, n_last_sense;
    logic [TW-1:0] r_last_reg, n_last_reg;
    logic [TW-1:0] r_deadline, n_deadline;
    logic r_pending, n_pending;
    logic r_heater, n_heater;
    logic r_fan, n_fan;
    logic r_fault, n_fault;
    logic r_over, n_over;
    logic [tgfg_pkg::MODE_W-1:0] r_mode, n_mode;

    logic [TW-1:0] w_diff;
    logic [TW-1:0] w_ref;
    logic [TW-1:0] w_period;
    logic          w_elapsed;
    logic          w_div_start;
    logic          w_div_done;
    logic [tgfg_pkg::NUM_W-1:0] w_num;
    logic [tgfg_pkg::DEN_W-1:0] w_den;
    logic [tgfg_pkg::NUM_W-1:0] w_quot;

    logic signed [CW-1:0] w_tl, w_tr, w_gl, w_gr, w_h, w_m;
    logic w_need, w_done, w_heat, w_stop, w_hot;

    // One shared wrapping subtract for every elapsed-time test, and one compare for all but the fan delay.
    always_comb begin
        w_ref    = r_last_edge;
        w_period = TW'(tgfg_pkg::DEBOUNCE_US);
        unique case (r_state)
            S_EDGE:  begin w_ref = r_last_edge;  w_period = TW'(tgfg_pkg::DEBOUNCE_US); end
            S_RPM:   begin w_ref = r_last_rpm;   w_period = TW'(tgfg_pkg::RPM_PERIOD_MS); end
            S_SENSE: begin w_ref = r_last_sense; w_period = TW'(tgfg_pkg::SENSE_PERIOD_MS); end
            S_REG:   begin w_ref = r_last_reg;   w_period = TW'(tgfg_pkg::REGULATE_PERIOD_MS); end
            S_DELAY: begin w_ref = r_deadline;   w_period = '0; end
            default: begin w_ref = r_last_edge;  w_period = TW'(tgfg_pkg::DEBOUNCE_US); end
        endcase
    end

    assign w_diff    = ((r_state == S_EDGE) ? r_tus : r_tms) - w_ref;
    assign w_elapsed = (w_diff >= w_period);

    assign w_num = tgfg_pkg::NUM_W'(r_tally) * tgfg_pkg::NUM_W'(tgfg_pkg::MS_PER_MIN);
    assign w_den = tgfg_pkg::DEN_W'(w_diff) * tgfg_pkg::DEN_W'(tgfg_pkg::PULSES_PER_REV);
    assign w_div_start = (r_state == S_RPM) && w_elapsed;

    tgfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_tl = CW'(r_tl);
    assign w_tr = CW'(r_tr);
    assign w_gl = $signed(CW'(i_cfg.target_left));
    assign w_gr = $signed(CW'(i_cfg.target_right));
    assign w_h  = $signed(CW'(i_cfg.hysteresis));
    assign w_m  = $signed(CW'(i_cfg.overheat_margin));

    assign w_need = (w_tl < w_gl - w_h) || (w_tr < w_gr - w_h);
    assign w_done = (w_tl > w_gl + w_h) && (w_tr > w_gr + w_h);
    assign w_heat = w_need && i_cfg.heater_allowed && !r_fault;
    assign w_stop = w_done || !i_cfg.heater_allowed;
    assign w_hot  = (w_tl > w_gl + w_m) || (w_tr > w_gr + w_m);

    always_comb begin
        n_state      = r_state;
        n_tally      = r_tally;
        n_last_edge  = r_last_edge;
        n_last_rpm   = r_last_rpm;
        n_rpm        = r_rpm;
        n_last_sense = r_last_sense;
        n_last_reg   = r_last_reg;
        n_deadline   = r_deadline;
        n_pending    = r_pending;
        n_heater     = r_heater;
        n_fan        = r_fan;
        n_fault      = r_fault;
        n_over       = r_over;
        n_mode       = r_mode;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_op)
                        tgfg_pkg::OP_TACH_EDGE: n_state = S_EDGE;
                        tgfg_pkg::OP_TICK:      n_state = S_RPM;
                        tgfg_pkg::OP_FAULT_RESET: begin
                            n_fault = 1'b0;
                            n_over  = 1'b0;
                            n_mode  = tgfg_pkg::MODE_IDLE;
                            n_state = S_DONE;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_EDGE: begin
                if (w_elapsed) begin
                    n_last_edge = r_tus;
                    if (r_tally != '1) begin
                        n_tally = r_tally + 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_RPM: begin
                n_state = w_elapsed ? S_DIV : S_FAN;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_rpm = (w_quot > tgfg_pkg::NUM_W'(tgfg_pkg::MAX_RPM)) ?
                            '0 : w_quot[tgfg_pkg::RPM_W-1:0];
                    n_tally    = '0;
                    n_last_rpm = r_tms;
                    n_state    = S_FAN;
                end
            end
            S_FAN: begin
                if (r_fan) begin
                    if (r_rpm < i_cfg.min_speed) begin
                        if (!r_fault) begin
                            n_fault  = 1'b1;
                            n_heater = 1'b0;
                            n_mode   = tgfg_pkg::MODE_SPEED_FAULT;
                        end
                    end else if (r_fault) begin
                        n_fault = 1'b0;
                        n_mode  = tgfg_pkg::MODE_IDLE;
                    end
                end else begin
                    n_fault = 1'b0;
                end
                n_state = S_GATE;
            end
            S_GATE: begin
                if (!i_cfg.control_enable || r_fault) begin
                    n_heater = 1'b0;
                    if (!i_cfg.control_enable && r_fan && !r_pending) begin
                        n_fan = 1'b0;
                    end
                    n_state = S_DELAY;
                end else begin
                    n_state = S_SENSE;
                end
            end
            S_SENSE: begin
                if (w_elapsed) begin
                    n_last_sense = r_tms;
                    if (w_hot) begin
                        if (!r_over) begin
                            n_over   = 1'b1;
                            n_mode   = tgfg_pkg::MODE_OVERHEAT;
                            n_heater = 1'b0;
                        end
                    end else if (r_over) begin
                        n_over = 1'b0;
                        n_mode = tgfg_pkg::MODE_IDLE;
                    end
                end
                n_state = S_REG;
            end
            S_REG: begin
                if (w_elapsed) begin
                    n_last_reg = r_tms;
                    if (!r_over) begin
                        if (w_heat && !r_heater) begin
                            n_heater = 1'b1;
                            n_mode   = tgfg_pkg::MODE_HEATING;
                            if (i_cfg.fan_allowed) begin
                                n_fan = 1'b1;
                            end
                        end else if (w_stop && r_heater) begin
                            n_heater   = 1'b0;
                            n_mode     = tgfg_pkg::MODE_COOLING;
                            n_deadline = r_tms + TW'(tgfg_pkg::FAN_DELAY_MS);
                            n_pending  = 1'b1;
                        end else if (!r_heater && !r_fan && !r_pending) begin
                            if (r_mode != tgfg_pkg::MODE_IDLE &&
                                r_mode != tgfg_pkg::MODE_SPEED_FAULT &&
                                r_mode != tgfg_pkg::MODE_OVERHEAT) begin
                                n_mode = tgfg_pkg::MODE_IDLE;
                            end
                        end
                    end
                    n_state = S_DELAY;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DELAY: begin
                // The delay has run out once the wrapped difference is non-negative.
                if (r_pending && !w_diff[TW-1] && !r_heater) begin
                    if (r_fan) begin
                        n_fan = 1'b0;
                        if (r_mode == tgfg_pkg::MODE_COOLING) begin
                            n_mode = tgfg_pkg::MODE_IDLE;
                        end
                    end
                    n_pending = 1'b0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tally      <= '0;
            r_last_edge  <= '0;
            r_last_rpm   <= '0;
            r_rpm        <= '0;
            r_last_sense <= '0;
            r_last_reg   <= '0;
            r_deadline   <= '0;
            r_pending    <= 1'b0;
            r_heater     <= 1'b0;
            r_fan        <= 1'b0;
            r_fault      <= 1'b0;
            r_over       <= 1'b0;
            r_mode       <= tgfg_pkg::MODE_IDLE;
        end else begin
            r_state      <= n_state;
            r_tally      <= n_tally;
            r_last_edge  <= n_last_edge;
            r_last_rpm   <= n_last_rpm;
            r_rpm        <= n_rpm;
            r_last_sense <= n_last_sense;
            r_last_reg   <= n_last_reg;
            r_deadline   <= n_deadline;
            r_pending    <= n_pending;
            r_heater     <= n_heater;
            r_fan        <= n_fan;
            r_fault      <= n_fault;
            r_over       <= n_over;
            r_mode       <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_req_valid) begin
            r_tus <= i_time_us;
            r_tms <= i_time_ms;
            r_tl  <= i_left_temp;
            r_tr  <= i_right_temp;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    assign o_res.heater_on   = r_heater;
    assign o_res.fan_on      = r_fan;
    assign o_res.fan_speed   = r_rpm;
    assign o_res.speed_fault = r_fault;
    assign o_res.overheat    = r_over;
    assign o_res.mode        = r_mode;

endmodule

### rtl/thermostat_with_fan_guard_core.sv
`timescale 1ns / 1ps
// A fault reset or an unused code goes straight to the result; a tach edge passes through
// the debounce check, and a control tick through the fan check and the control steps.
// A fan-speed update waits on the bit-serial divider, one quotient bit per cycle.
// One request is in work at a time; the next is taken in the cycle after the result moves
// to the output register.
// Synchronous active-low reset clears timers, counters and flags and loads config defaults.
module thermostat_with_fan_guard_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [tgfg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tgfg_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // operation[1:0], time_us[33:2], time_ms[65:34], left_temp[77:66],
    // right_temp[89:78], zero padding[95:90]
    input  logic [95:0]                          s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // heater_on[0], fan_on[1], fan_speed[15:2], speed_fault[16], overheat[17],
    // mode[20:18], zero padding[23:21]
    output logic [23:0]                          m_axis_tdata
);

    tgfg_pkg::t_cfg    r_cfg;
    tgfg_pkg::t_result w_res;
    tgfg_pkg::t_result r_out;
    logic              r_out_valid;
    logic              w_res_valid;
    logic              w_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.control_enable  <= 1'b0;
            r_cfg.target_left     <= tgfg_pkg::TGT_W'(640);
            r_cfg.target_right    <= tgfg_pkg::TGT_W'(640);
            r_cfg.heater_allowed  <= 1'b1;
            r_cfg.fan_allowed     <= 1'b1;
            r_cfg.hysteresis      <= tgfg_pkg::HYST_W'(8);
            r_cfg.overheat_margin <= tgfg_pkg::MARG_W'(80);
            r_cfg.min_speed       <= tgfg_pkg::RPM_W'(500);
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                tgfg_pkg::CFG_CONTROL_ENABLE:  r_cfg.control_enable  <= i_cfg_wdata[0];
                tgfg_pkg::CFG_TARGET_LEFT:     r_cfg.target_left     <=
                                                   i_cfg_wdata[tgfg_pkg::TGT_W-1:0];
                tgfg_pkg::CFG_TARGET_RIGHT:    r_cfg.target_right    <=
                                                   i_cfg_wdata[tgfg_pkg::TGT_W-1:0];
                tgfg_pkg::CFG_HEATER_ALLOWED:  r_cfg.heater_allowed  <= i_cfg_wdata[0];
                tgfg_pkg::CFG_FAN_ALLOWED:     r_cfg.fan_allowed     <= i_cfg_wdata[0];
                tgfg_pkg::CFG_HYSTERESIS:      r_cfg.hysteresis      <=
                                                   i_cfg_wdata[tgfg_pkg::HYST_W-1:0];
                tgfg_pkg::CFG_OVERHEAT_MARGIN: r_cfg.overheat_margin <=
                                                   i_cfg_wdata[tgfg_pkg::MARG_W-1:0];
                tgfg_pkg::CFG_MIN_SPEED:       r_cfg.min_speed       <=
                                                   i_cfg_wdata[tgfg_pkg::RPM_W-1:0];
                default: ;
            endcase
        end
    end

    tgfg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_req_valid  (s_axis_tvalid),
        .o_req_ready  (s_axis_tready),
        .i_op         (s_axis_tdata[1:0]),
        .i_time_us    (s_axis_tdata[33:2]),
        .i_time_ms    (s_axis_tdata[65:34]),
        .i_left_temp  (s_axis_tdata[77:66]),
        .i_right_temp (s_axis_tdata[89:78]),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res        (w_res)
    );

    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out};

endmodule
